// ===== design/key_sort_asc_desc_assert.svh =====
// ----------------------------------------------------------------------------
// key_sort_asc_desc assertion macros
// Property wrappers used by the sorter; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef KEY_SORT_ASC_DESC_ASSERT_SVH
`define KEY_SORT_ASC_DESC_ASSERT_SVH

`ifndef SYNTH
`define KSAD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ksad check failed");
`define KSAD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ksad check failed");
`else
`define KSAD_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define KSAD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== design/ksad_pkg.sv =====
// ----------------------------------------------------------------------------
// ksad_pkg
// Shared constants and types of the key sorter.
// ----------------------------------------------------------------------------
package ksad_pkg;

   localparam int MAX_ITEMS_DEF = 64;
   localparam int KEY_BITS_DEF  = 16;
   localparam int IN_KEY_BITS   = 16;
   localparam int OUT_IDX_BITS  = 6;

   // per-cycle command to every cell of the chain
   typedef struct packed {
      logic insert;
      logic shift_out;
   } chain_ctl_type;

endpackage

// ===== design/ksad_if.sv =====
// ----------------------------------------------------------------------------
// ksad interfaces
// Valid/ready channels of the key sorter: request, response and csr write.
// ----------------------------------------------------------------------------
interface ksad_req_if;
   logic                              valid;
   logic                              ready;
   logic [ksad_pkg::IN_KEY_BITS-1:0]  key_year;
   logic                              last_item;

   modport source (output valid, output key_year, output last_item, input ready);
   modport sink   (input valid, input key_year, input last_item, output ready);
endinterface

interface ksad_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [ksad_pkg::IN_KEY_BITS-1:0]  sorted_key;
   logic [ksad_pkg::OUT_IDX_BITS-1:0] source_index;
   logic                              overflowed;
   logic                              last_result;

   modport source (output valid, output sorted_key, output source_index,
                   output overflowed, output last_result, input ready);
   modport sink   (input valid, input sorted_key, input source_index,
                   input overflowed, input last_result, output ready);
endinterface

interface ksad_csr_if;
   logic valid;
   logic ready;
   logic sort_descending;

   modport source (output valid, output sort_descending, input ready);
   modport sink   (input valid, input sort_descending, output ready);
endinterface

// ===== design/ksad_cell.sv =====
// ----------------------------------------------------------------------------
// ksad_cell
// One slot of the insertion chain: holds a key, its load index and a valid bit.
// ----------------------------------------------------------------------------
module ksad_cell #(
   parameter int KEY_BITS = ksad_pkg::KEY_BITS_DEF,
   parameter int IDX_BITS = ksad_pkg::OUT_IDX_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ksad_pkg::chain_ctl_type   ctl,
   input  logic                      desc,
   input  logic [KEY_BITS-1:0]       new_key,
   input  logic [IDX_BITS-1:0]       new_idx,
   input  logic                      left_before,
   input  logic [KEY_BITS-1:0]       left_key,
   input  logic [IDX_BITS-1:0]       left_idx,
   input  logic                      left_valid,
   input  logic [KEY_BITS-1:0]       right_key,
   input  logic [IDX_BITS-1:0]       right_idx,
   input  logic                      right_valid,
   output logic [KEY_BITS-1:0]       key_out,
   output logic [IDX_BITS-1:0]       idx_out,
   output logic                      valid_out,
   output logic                      before_out
);

   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in;
   logic                valid_ff, valid_in;
   logic                ahead;

   // new key lands ahead of this slot; equal keys stay put, so ties keep load order
   assign ahead = !valid_ff || (desc ? (new_key > key_ff) : (new_key < key_ff));

   always_comb begin
      key_in   = key_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (ctl.insert) begin
         if (left_before) begin
            key_in   = left_key;
            idx_in   = left_idx;
            valid_in = left_valid;
         end else if (ahead) begin
            key_in   = new_key;
            idx_in   = new_idx;
            valid_in = 1'b1;
         end
      end else if (ctl.shift_out) begin
         key_in   = right_key;
         idx_in   = right_idx;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      idx_ff <= idx_in;
   end

   assign key_out    = key_ff;
   assign idx_out    = idx_ff;
   assign valid_out  = valid_ff;
   assign before_out = ahead;

endmodule

// ===== design/key_sort_asc_desc.sv =====
// ----------------------------------------------------------------------------
// key_sort_asc_desc
// Stable ascending/descending sorter of up to MAX_ITEMS keys per set.
// ----------------------------------------------------------------------------
// Keys are loaded one word per cycle into a key memory; keys past MAX_ITEMS
// are dropped and flag overflow on every result of the set. After the word
// marked last, the memory is read one entry per cycle into a chain of
// insertion cells, during which no request is taken. The sorted set then
// leaves the chain head at one word per cycle while rsp.ready is high, and
// the block takes a new set in the cycle after the last result is taken.
// Direction is the sort_descending register at sort time; equal keys leave
// in load order. The csr port is always ready.
module key_sort_asc_desc #(
   parameter int MAX_ITEMS = ksad_pkg::MAX_ITEMS_DEF,
   parameter int KEY_BITS  = ksad_pkg::KEY_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   ksad_req_if.sink    req,
   ksad_rsp_if.source  rsp,
   ksad_csr_if.sink    csr
);

`include "key_sort_asc_desc_assert.svh"

   localparam int ADDR_W   = $clog2(MAX_ITEMS);
   localparam int CNT_W    = $clog2(MAX_ITEMS + 1);
   localparam int IN_KEY_W = ksad_pkg::IN_KEY_BITS;
   localparam int OUT_IDX  = ksad_pkg::OUT_IDX_BITS;

   typedef enum logic [1:0] {LOAD, SORT, DRAIN} state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic [CNT_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic               rd_valid_ff, rd_valid_in;
   logic               desc_ff;

   logic [KEY_BITS-1:0] key_mem [MAX_ITEMS];
   logic [KEY_BITS-1:0] rd_key_ff;
   logic [ADDR_W-1:0]   rd_idx_ff;

   logic req_fire, rsp_fire, has_room;
   ksad_pkg::chain_ctl_type ctl;

   logic [KEY_BITS-1:0] cell_key   [MAX_ITEMS];
   logic [ADDR_W-1:0]   cell_idx   [MAX_ITEMS];
   logic                cell_valid [MAX_ITEMS];
   logic                cell_before[MAX_ITEMS];

   assign req_fire = req.valid && req.ready;
   assign rsp_fire = rsp.valid && rsp.ready;
   assign has_room = count_ff < CNT_W'(MAX_ITEMS);

   // csr
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         desc_ff <= 1'b0;
      end else if (csr.valid) begin
         desc_ff <= csr.sort_descending;
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      rd_ptr_in   = rd_ptr_ff;
      rd_valid_in = 1'b0;
      unique case (state_ff)
         LOAD: begin
            if (req_fire) begin
               if (has_room) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req.last_item) begin
                  state_in  = SORT;
                  rd_ptr_in = '0;
               end
            end
         end
         SORT: begin
            if (rd_ptr_ff != count_ff) begin
               rd_ptr_in   = rd_ptr_ff + CNT_W'(1);
               rd_valid_in = 1'b1;
            end else if (!rd_valid_ff) begin
               state_in = DRAIN;
            end
         end
         DRAIN: begin
            if (rsp_fire && rsp.last_result) begin
               state_in  = LOAD;
               count_in  = '0;
               ovf_in    = 1'b0;
               rd_ptr_in = '0;
            end
         end
         default: begin
            state_in = LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= LOAD;
         count_ff    <= '0;
         ovf_ff      <= 1'b0;
         rd_ptr_ff   <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         ovf_ff      <= ovf_in;
         rd_ptr_ff   <= rd_ptr_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   // key memory: address is the load index
   always_ff @(posedge clock) begin
      if (state_ff == LOAD && req_fire && has_room) begin
         key_mem[count_ff[ADDR_W-1:0]] <= KEY_BITS'(req.key_year);
      end
   end

   always_ff @(posedge clock) begin
      rd_key_ff <= key_mem[rd_ptr_ff[ADDR_W-1:0]];
      rd_idx_ff <= rd_ptr_ff[ADDR_W-1:0];
   end

   assign ctl.insert    = rd_valid_ff;
   assign ctl.shift_out = rsp_fire;

   // insertion chain
   for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
      logic                left_before, left_valid, right_valid;
      logic [KEY_BITS-1:0] left_key, right_key;
      logic [ADDR_W-1:0]   left_idx, right_idx;

      if (g == 0) begin : g_head
         assign left_before = 1'b0;
         assign left_key    = '0;
         assign left_idx    = '0;
         assign left_valid  = 1'b0;
      end else begin : g_body
         assign left_before = cell_before[g-1];
         assign left_key    = cell_key[g-1];
         assign left_idx    = cell_idx[g-1];
         assign left_valid  = cell_valid[g-1];
      end

      if (g == MAX_ITEMS - 1) begin : g_tail
         assign right_key   = '0;
         assign right_idx   = '0;
         assign right_valid = 1'b0;
      end else begin : g_mid
         assign right_key   = cell_key[g+1];
         assign right_idx   = cell_idx[g+1];
         assign right_valid = cell_valid[g+1];
      end

      ksad_cell #(
         .KEY_BITS (KEY_BITS),
         .IDX_BITS (ADDR_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .desc        (desc_ff),
         .new_key     (rd_key_ff),
         .new_idx     (rd_idx_ff),
         .left_before (left_before),
         .left_key    (left_key),
         .left_idx    (left_idx),
         .left_valid  (left_valid),
         .right_key   (right_key),
         .right_idx   (right_idx),
         .right_valid (right_valid),
         .key_out     (cell_key[g]),
         .idx_out     (cell_idx[g]),
         .valid_out   (cell_valid[g]),
         .before_out  (cell_before[g])
      );
   end

   // ports
   assign req.ready        = (state_ff == LOAD);
   assign rsp.valid        = (state_ff == DRAIN) && cell_valid[0];
   assign rsp.sorted_key   = IN_KEY_W'(cell_key[0]);
   assign rsp.source_index = OUT_IDX'(cell_idx[0]);
   assign rsp.overflowed   = ovf_ff;
   assign rsp.last_result  = !cell_valid[1];

   `KSAD_ASSERT_IMPLY(a_no_overlap, clock, reset, rsp.valid, !req.ready)
   `KSAD_ASSERT_IMPLY(a_head_full, clock, reset, state_ff == DRAIN, cell_valid[0])
   `KSAD_ASSERT_NEXT(a_set_closes, clock, reset, req_fire && req.last_item, !req.ready)
   `KSAD_ASSERT_NEXT(a_reopen, clock, reset, rsp_fire && rsp.last_result, req.ready)

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Streams key sets into key_sort_asc_desc with random gaps and response
// stalls, predicts the stable sorted order of every set and checks each
// response word field by field, across both sort directions.
// ----------------------------------------------------------------------------
module testbench;

   localparam int SET_CAP = ksad_pkg::MAX_ITEMS_DEF;
   localparam int KEY_W   = ksad_pkg::IN_KEY_BITS;
   localparam int IDX_W   = ksad_pkg::OUT_IDX_BITS;

   typedef struct {
      logic [KEY_W-1:0] key_year;
      logic             last_item;
   } key_word_type;

   typedef struct {
      logic [KEY_W-1:0] sorted_key;
      logic [IDX_W-1:0] source_index;
      logic             overflowed;
      logic             last_result;
   } sorted_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ksad_req_if req_bus ();
   ksad_rsp_if rsp_bus ();
   ksad_csr_if csr_bus ();

   key_sort_asc_desc u_top (
      .clock(clock),
      .reset(reset),
      .req  (req_bus),
      .rsp  (rsp_bus),
      .csr  (csr_bus)
   );

   always #5 clock = ~clock;

   key_word_type    pending[$];
   sorted_word_type sorted_words[$];

   // shadow of the set being loaded
   logic [KEY_W-1:0] set_keys [SET_CAP];
   int set_count      = 0;
   bit set_overflow   = 1'b0;
   bit cfg_descending = 1'b0;

   int errors      = 0;
   int keys_taken  = 0;
   int keys_queued = 0;
   bit req_fire    = 1'b0;
   bit rsp_fire    = 1'b0;
   bit req_idle    = 1'b1;
   bit rsp_idle    = 1'b1;
   int req_gap     = 0;
   int rsp_hold    = 0;

   function automatic bit ahead_of(input logic [KEY_W-1:0] ka, input int ia,
                                   input logic [KEY_W-1:0] kb, input int ib,
                                   input bit desc);
      if (ka != kb) return desc ? (ka > kb) : (ka < kb);
      return ia < ib;
   endfunction

   // store one key; on the last word sort the set and queue its results
   function automatic void load_key(input logic [KEY_W-1:0] key, input logic last);
      logic [KEY_W-1:0] keys [SET_CAP];
      int               idxs [SET_CAP];
      logic [KEY_W-1:0] k;
      int               x;
      int               j;
      sorted_word_type  w;
      if (set_count < SET_CAP) begin
         set_keys[set_count] = key;
         set_count++;
      end else begin
         set_overflow = 1'b1;
      end
      if (last) begin
         for (int i = 0; i < set_count; i++) begin
            keys[i] = set_keys[i];
            idxs[i] = i;
         end
         for (int i = 1; i < set_count; i++) begin
            k = keys[i];
            x = idxs[i];
            j = i;
            while (j > 0 && ahead_of(k, x, keys[j-1], idxs[j-1], cfg_descending)) begin
               keys[j] = keys[j-1];
               idxs[j] = idxs[j-1];
               j--;
            end
            keys[j] = k;
            idxs[j] = x;
         end
         for (int i = 0; i < set_count; i++) begin
            w.sorted_key   = keys[i];
            w.source_index = idxs[i][IDX_W-1:0];
            w.overflowed   = set_overflow;
            w.last_result  = (i == set_count - 1);
            sorted_words.push_back(w);
         end
         set_count    = 0;
         set_overflow = 1'b0;
      end
   endfunction

   function automatic void check_field(input string name, input logic [KEY_W-1:0] want,
                                       input logic [KEY_W-1:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
   endfunction

   // monitor: handshakes, prediction and checking at the rising edge
   always @(posedge clock) begin
      sorted_word_type want;
      req_fire <= !reset && req_bus.valid && req_bus.ready;
      rsp_fire <= !reset && rsp_bus.valid && rsp_bus.ready;
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) cfg_descending = csr_bus.sort_descending;
         if (req_bus.valid && req_bus.ready) begin
            load_key(req_bus.key_year, req_bus.last_item);
            keys_taken++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (sorted_words.size() == 0) begin
               errors++;
               $display("%0t: unexpected word, expected none actual key %0h index %0d",
                        $time, rsp_bus.sorted_key, rsp_bus.source_index);
            end else begin
               want = sorted_words.pop_front();
               check_field("sorted_key", want.sorted_key, rsp_bus.sorted_key);
               check_field("source_index", KEY_W'(want.source_index),
                           KEY_W'(rsp_bus.source_index));
               check_field("overflowed", KEY_W'(want.overflowed),
                           KEY_W'(rsp_bus.overflowed));
               check_field("last_result", KEY_W'(want.last_result),
                           KEY_W'(rsp_bus.last_result));
            end
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      key_word_type w;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_fire) begin
         if (req_gap > 0) begin
            req_bus.valid <= 1'b0;
            req_gap       <= req_gap - 1;
         end else if (pending.size() > 0) begin
            w = pending.pop_front();
            req_bus.valid     <= 1'b1;
            req_bus.key_year  <= w.key_year;
            req_bus.last_item <= w.last_item;
            req_gap           <= req_idle ? $urandom_range(0, 8) : 0;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // response sink, a fresh random stall, possibly none, after each word taken while rsp_idle is set
   always @(negedge clock) begin
      int s;
      s = rsp_hold;
      if (rsp_fire) s = rsp_idle ? $urandom_range(0, 8) : 0;
      if (s > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold      <= s - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
         rsp_hold      <= 0;
      end
   end

   task automatic push_key(input logic [KEY_W-1:0] key, input logic last);
      key_word_type w;
      w.key_year  = key;
      w.last_item = last;
      pending.push_back(w);
      keys_queued++;
   endtask

   // wait until every queued word is taken and every result has come back
   task automatic drain();
      do @(negedge clock); while (keys_taken != keys_queued || sorted_words.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_direction(input bit desc);
      csr_bus.valid           <= 1'b1;
      csr_bus.sort_descending <= desc;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   function automatic logic [KEY_W-1:0] pick_key(input int mode);
      case (mode)
         0: return KEY_W'($urandom_range(0, 3));
         1: begin
            case ($urandom_range(0, 3))
               0: return 16'h0000;
               1: return 16'hffff;
               2: return 16'h8000;
               default: return 16'h7fff;
            endcase
         end
         default: return KEY_W'($urandom_range(0, 65535));
      endcase
   endfunction

   initial begin
      int ph;
      int nsets;
      int n;
      int mode;
      req_bus.valid           = 1'b0;
      req_bus.key_year        = '0;
      req_bus.last_item       = 1'b0;
      rsp_bus.ready           = 1'b0;
      csr_bus.valid           = 1'b0;
      csr_bus.sort_descending = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, ascending: single extremes, equal keys, a mixed set
      write_direction(1'b0);
      push_key(16'h0000, 1'b1);
      push_key(16'hffff, 1'b1);
      push_key(16'h0005, 1'b0); push_key(16'h0005, 1'b0);
      push_key(16'h0005, 1'b0); push_key(16'h0005, 1'b1);
      push_key(16'hffff, 1'b0); push_key(16'h0000, 1'b0); push_key(16'h8000, 1'b0);
      push_key(16'h7fff, 1'b0); push_key(16'h0001, 1'b0); push_key(16'hfffe, 1'b1);
      drain();

      // directed, descending: ties at both ends, then a single key
      write_direction(1'b1);
      push_key(16'h0000, 1'b0); push_key(16'hffff, 1'b0); push_key(16'h0000, 1'b0);
      push_key(16'hffff, 1'b0); push_key(16'h5555, 1'b0); push_key(16'haaaa, 1'b1);
      push_key(16'h1234, 1'b1);
      drain();

      ph = 0;
      while (keys_queued < 430) begin
         req_idle <= (ph % 4 != 3);
         rsp_idle <= (ph % 5 != 2);
         write_direction((ph % 3 == 2) ? 1'($urandom_range(0, 1)) : 1'(ph % 2));
         nsets = $urandom_range(2, 5);
         for (int s = 0; s < nsets; s++) begin
            // a full set and an overflowing one early on, otherwise mostly small
            if (ph == 1 && s == 0) n = SET_CAP;
            else if (ph == 2 && s == 0) n = SET_CAP + 2;
            else if ($urandom_range(0, 19) == 0) n = $urandom_range(SET_CAP - 4, SET_CAP + 6);
            else n = $urandom_range(1, 10);
            mode = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) push_key(pick_key(mode), i == n - 1);
         end
         drain();
         ph++;
      end

      repeat (20) @(negedge clock);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/ksad_pkg.sv
design/ksad_if.sv
design/ksad_cell.sv
design/key_sort_asc_desc.sv
bench/testbench.sv
